// ===== hdl/clipped_line_rasterizer_assert.svh =====
// assertion macros used by the checker of the line rasterizer
`ifndef CLIPPED_LINE_RASTERIZER_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_ASSERT_SVH

// implication checked in the same cycle
`define CLR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("clr check failed");

// implication checked in the next cycle
`define CLR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("clr check failed");

`endif

// ===== hdl/clr_pkg.sv =====
`default_nettype none

package clr_pkg;

  localparam int FB_WIDTH   = 128;
  localparam int FB_HEIGHT  = 128;
  localparam int COORD_BITS = 11;

  localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W   = $clog2(FB_DEPTH);
  localparam int XI_W     = $clog2(FB_WIDTH);
  localparam int YI_W     = $clog2(FB_HEIGHT);
  localparam int COLOR_W  = 24;
  localparam int DIM_W    = 8;
  localparam int CFG_IDX_W = 1;

  // walk coordinates carry one extra bit for the overshoot of a diagonal
  localparam int PIX_W = COORD_BITS + 1;
  localparam int D_W   = COORD_BITS + 1;
  localparam int R_W   = D_W + 1;

  localparam int XD_W  = $clog2(FB_WIDTH + 1);
  localparam int YD_W  = $clog2(FB_HEIGHT + 1);
  localparam int CMP_A = (PIX_W > DIM_W + 1) ? PIX_W : DIM_W + 1;
  localparam int CMP_B = (XD_W > YD_W) ? XD_W : YD_W;
  localparam int CMP_W = (CMP_A > CMP_B) ? CMP_A : CMP_B;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PIX_W-1:0]      pix_coord_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [COLOR_W-1:0]           color_t;
  typedef logic [DIM_W-1:0]             dim_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam cfg_idx_t CFG_ACTIVE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_ACTIVE_HEIGHT = 1'b1;

  localparam dim_t AREA_RESET = 8'd128;

  typedef struct packed {
    logic       start;
    pix_coord_t sx;
    pix_coord_t sy;
    pix_coord_t ex;
    pix_coord_t ey;
  } walk_cmd_t;

  typedef struct packed {
    logic       vld;
    logic       last;
    pix_coord_t x;
    pix_coord_t y;
  } walk_pix_t;

  function automatic logic in_area_fn(pix_coord_t x, pix_coord_t y, dim_t aw, dim_t ah);
    logic [CMP_W-1:0] xc;
    logic [CMP_W-1:0] yc;
    xc = CMP_W'($unsigned(x));
    yc = CMP_W'($unsigned(y));
    return !x[PIX_W-1] && !y[PIX_W-1] &&
           (xc < CMP_W'(aw)) && (xc < CMP_W'(FB_WIDTH)) &&
           (yc < CMP_W'(ah)) && (yc < CMP_W'(FB_HEIGHT));
  endfunction

  // only meaningful for points inside the store
  function automatic addr_t addr_fn(pix_coord_t x, pix_coord_t y);
    logic [CMP_W-1:0] xc;
    logic [CMP_W-1:0] yc;
    xc = CMP_W'($unsigned(x));
    yc = CMP_W'($unsigned(y));
    return ADDR_W'(ADDR_W'(yc[YI_W-1:0]) * ADDR_W'(FB_WIDTH)) + ADDR_W'(xc[XI_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/clr_in_if.sv =====
`default_nettype none

interface clr_in_if;
  logic            valid;
  logic            ready;
  logic            operation;
  clr_pkg::coord_t start_x;
  clr_pkg::coord_t start_y;
  clr_pkg::coord_t end_x;
  clr_pkg::coord_t end_y;
  clr_pkg::color_t line_color;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/clr_out_if.sv =====
`default_nettype none

interface clr_out_if;
  logic            valid;
  logic            ready;
  clr_pkg::color_t pixel_color;
  logic            in_area;

  modport source (output valid, pixel_color, in_area, input ready);
  modport sink (input valid, pixel_color, in_area, output ready);
endinterface

`default_nettype wire

// ===== hdl/clr_cfg_if.sv =====
`default_nettype none

interface clr_cfg_if;
  logic              valid;
  logic              ready;
  clr_pkg::cfg_idx_t index;
  clr_pkg::dim_t     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/clr_fb_ram.sv =====
`default_nettype none

module clr_fb_ram #(
  parameter int DEPTH  = 16384,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/clr_line_walker.sv =====
`default_nettype none

module clr_line_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  clr_pkg::walk_cmd_t cmd,
  output clr_pkg::walk_pix_t pix
);

  typedef enum logic [4:0] {
    W_IDLE  = 5'b00001,
    W_SETUP = 5'b00010,
    W_MAIN  = 5'b00100,
    W_STEP  = 5'b01000,
    W_FINAL = 5'b10000
  } wstate_t;

  wstate_t state_r, state_nxt;
  clr_pkg::walk_pix_t pix_r, pix_nxt;

  clr_pkg::pix_coord_t x1_r, y1_r, x2_r, y2_r;
  clr_pkg::pix_coord_t x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  clr_pkg::pix_coord_t m_r, n_r, mend_r, nend_r;
  clr_pkg::pix_coord_t m_nxt, n_nxt, mend_nxt, nend_nxt;
  logic [clr_pkg::D_W-1:0] dmaj_r, dmin_r, dmaj_nxt, dmin_nxt;
  logic [clr_pkg::R_W-1:0] rem_r, rem_nxt;
  logic xmaj_r, xmaj_nxt, neg_r, neg_nxt;

  // setup terms
  logic [clr_pkg::D_W-1:0] dx, dy;
  logic xmaj_c, swap_c, pt_c;
  clr_pkg::pix_coord_t ax, ay, bx, by;

  // walk terms
  logic [clr_pkg::R_W-1:0] rem_sum;
  logic                    minor_step;
  clr_pkg::pix_coord_t     n_step;
  clr_pkg::pix_coord_t     cur_x, cur_y, end_x, end_y;

  always_comb begin
    dx = (x2_r >= x1_r) ? clr_pkg::D_W'(x2_r - x1_r) : clr_pkg::D_W'(x1_r - x2_r);
    dy = (y2_r >= y1_r) ? clr_pkg::D_W'(y2_r - y1_r) : clr_pkg::D_W'(y1_r - y2_r);
    xmaj_c = dx >= dy;
    pt_c   = (dx == '0) && (dy == '0);
    swap_c = xmaj_c ? (x2_r < x1_r) : (y2_r < y1_r);
    ax = swap_c ? x2_r : x1_r;
    ay = swap_c ? y2_r : y1_r;
    bx = swap_c ? x1_r : x2_r;
    by = swap_c ? y1_r : y2_r;
  end

  always_comb begin
    rem_sum    = rem_r + clr_pkg::R_W'(dmin_r);
    minor_step = rem_sum >= clr_pkg::R_W'(dmaj_r);
    n_step     = neg_r ? n_r - clr_pkg::PIX_W'(1) : n_r + clr_pkg::PIX_W'(1);
    cur_x      = xmaj_r ? m_r : n_r;
    cur_y      = xmaj_r ? n_r : m_r;
    end_x      = xmaj_r ? mend_r : nend_r;
    end_y      = xmaj_r ? nend_r : mend_r;
  end

  always_comb begin
    state_nxt = state_r;
    pix_nxt   = '0;
    x1_nxt = x1_r; y1_nxt = y1_r; x2_nxt = x2_r; y2_nxt = y2_r;
    m_nxt = m_r; n_nxt = n_r; mend_nxt = mend_r; nend_nxt = nend_r;
    dmaj_nxt = dmaj_r; dmin_nxt = dmin_r; rem_nxt = rem_r;
    xmaj_nxt = xmaj_r; neg_nxt = neg_r;
    unique case (state_r)
      W_IDLE: begin
        if (cmd.start) begin
          x1_nxt = cmd.sx; y1_nxt = cmd.sy; x2_nxt = cmd.ex; y2_nxt = cmd.ey;
          state_nxt = W_SETUP;
        end
      end
      W_SETUP: begin
        xmaj_nxt = xmaj_c;
        m_nxt    = xmaj_c ? ax : ay;
        n_nxt    = xmaj_c ? ay : ax;
        mend_nxt = xmaj_c ? bx : by;
        nend_nxt = xmaj_c ? by : bx;
        neg_nxt  = xmaj_c ? (by < ay) : (bx < ax);
        dmaj_nxt = xmaj_c ? dx : dy;
        dmin_nxt = xmaj_c ? dy : dx;
        rem_nxt  = '0;
        state_nxt = pt_c ? W_FINAL : W_MAIN;
      end
      W_MAIN: begin
        pix_nxt.vld = 1'b1;
        pix_nxt.x   = cur_x;
        pix_nxt.y   = cur_y;
        if (minor_step) begin
          rem_nxt   = rem_sum - clr_pkg::R_W'(dmaj_r);
          n_nxt     = n_step;
          state_nxt = W_STEP;
        end else begin
          rem_nxt = rem_sum;
          if (m_r == mend_r) begin
            state_nxt = W_FINAL;
          end else begin
            m_nxt = m_r + clr_pkg::PIX_W'(1);
          end
        end
      end
      W_STEP: begin
        // extra pixel after a minor step
        pix_nxt.vld = 1'b1;
        pix_nxt.x   = cur_x;
        pix_nxt.y   = cur_y;
        if (m_r == mend_r) begin
          state_nxt = W_FINAL;
        end else begin
          m_nxt     = m_r + clr_pkg::PIX_W'(1);
          state_nxt = W_MAIN;
        end
      end
      W_FINAL: begin
        pix_nxt.vld  = 1'b1;
        pix_nxt.last = 1'b1;
        pix_nxt.x    = end_x;
        pix_nxt.y    = end_y;
        state_nxt    = W_IDLE;
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      pix_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x1_nxt; y1_r <= y1_nxt; x2_r <= x2_nxt; y2_r <= y2_nxt;
    m_r <= m_nxt; n_r <= n_nxt; mend_r <= mend_nxt; nend_r <= nend_nxt;
    dmaj_r <= dmaj_nxt; dmin_r <= dmin_nxt; rem_r <= rem_nxt;
    xmaj_r <= xmaj_nxt; neg_r <= neg_nxt;
  end

  assign pix = pix_r;

endmodule

`default_nettype wire

// ===== hdl/clipped_line_rasterizer.sv =====
`default_nettype none

// Line rasterizer with its own 128 x 128 frame store of 24-bit colours. A draw transfer
// walks the line from start to end point and writes one pixel per cycle through the single
// write port of the store; points outside the active width and height (and negative ones)
// are dropped but still walked. A draw result (colour zero, in_area zero) is valid once the
// walker has given the last pixel of the line, after S_DRAW and S_RESP. A read result for a
// point inside the area passes the registered store read and S_READ before S_RESP; one for
// a point outside goes straight to S_RESP. Items are handled one at a time; the input
// is taken again as soon as the result sits in the output register, even if it is not yet
// taken, so the next transfer can come in the same cycle in which the result appears; a
// result that waits in the output register holds the next one back. After reset the store
// is zeroed by a clearing pass over all FB_WIDTH * FB_HEIGHT addresses (16384) during which
// no item is taken; configuration writes are taken at any time.
module clipped_line_rasterizer (
  input  logic         clk,
  input  logic         rst_n,
  clr_in_if.sink       in_ch,
  clr_out_if.source    out_ch,
  clr_cfg_if.sink      cfg_ch
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DRAW  = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // clearing pass
  clr_pkg::addr_t clr_cnt_r, clr_cnt_nxt;

  // area registers
  clr_pkg::dim_t aw_r, aw_nxt, ah_r, ah_nxt;

  // line colour of the draw in progress
  clr_pkg::color_t color_r, color_nxt;

  // pending result and output register
  clr_pkg::color_t res_color_r, res_color_nxt;
  logic            res_area_r, res_area_nxt;
  clr_pkg::color_t out_color_r, out_color_nxt;
  logic            out_area_r, out_area_nxt;
  logic            out_valid_r, out_valid_nxt;

  // frame store ports
  logic            wr_en, rd_en;
  clr_pkg::addr_t  wr_addr, rd_addr;
  clr_pkg::color_t wr_data, rd_data;

  clr_pkg::walk_cmd_t walk_cmd;
  clr_pkg::walk_pix_t walk_pix;

  logic                in_fire;
  logic                out_free;
  logic                rd_inside;
  clr_pkg::pix_coord_t sx_ext, sy_ext;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign sx_ext    = clr_pkg::PIX_W'(in_ch.start_x);
  assign sy_ext    = clr_pkg::PIX_W'(in_ch.start_y);
  assign rd_inside = clr_pkg::in_area_fn(sx_ext, sy_ext, aw_r, ah_r);

  // draw command goes straight to the walker on the input transfer
  always_comb begin
    walk_cmd.start = in_fire && (in_ch.operation == clr_pkg::OP_DRAW);
    walk_cmd.sx    = sx_ext;
    walk_cmd.sy    = sy_ext;
    walk_cmd.ex    = clr_pkg::PIX_W'(in_ch.end_x);
    walk_cmd.ey    = clr_pkg::PIX_W'(in_ch.end_y);
  end

  clr_line_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (walk_cmd),
    .pix   (walk_pix)
  );

  // write port: zeros during the clearing pass, clipped line pixels otherwise
  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = walk_pix.vld && clr_pkg::in_area_fn(walk_pix.x, walk_pix.y, aw_r, ah_r);
      wr_addr = clr_pkg::addr_fn(walk_pix.x, walk_pix.y);
      wr_data = color_r;
    end
  end

  // read port: only for a read that lands inside the area
  assign rd_en   = in_fire && (in_ch.operation == clr_pkg::OP_READ) && rd_inside;
  assign rd_addr = clr_pkg::addr_fn(sx_ext, sy_ext);

  clr_fb_ram #(
    .DEPTH  (clr_pkg::FB_DEPTH),
    .WIDTH  (clr_pkg::COLOR_W),
    .ADDR_W (clr_pkg::ADDR_W)
  ) u_fb_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // configuration writes
  always_comb begin
    aw_nxt = aw_r;
    ah_nxt = ah_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        clr_pkg::CFG_ACTIVE_WIDTH:  aw_nxt = cfg_ch.data;
        clr_pkg::CFG_ACTIVE_HEIGHT: ah_nxt = cfg_ch.data;
      endcase
    end
  end

  // control sequence
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    color_nxt     = color_r;
    res_color_nxt = res_color_r;
    res_area_nxt  = res_area_r;
    out_color_nxt = out_color_r;
    out_area_nxt  = out_area_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + clr_pkg::ADDR_W'(1);
        if (clr_cnt_r == clr_pkg::ADDR_W'(clr_pkg::FB_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          color_nxt     = in_ch.line_color;
          res_color_nxt = '0;
          res_area_nxt  = 1'b0;
          if (in_ch.operation == clr_pkg::OP_DRAW) begin
            state_nxt = S_DRAW;
          end else if (rd_inside) begin
            state_nxt = S_READ;
          end else begin
            // read outside the area answers zero
            state_nxt = S_RESP;
          end
        end
      end
      S_DRAW: begin
        // the last pixel is written at this edge
        if (walk_pix.vld && walk_pix.last) begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        res_color_nxt = rd_data;
        res_area_nxt  = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_color_nxt = res_color_r;
          out_area_nxt  = res_area_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      aw_r        <= clr_pkg::AREA_RESET;
      ah_r        <= clr_pkg::AREA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      aw_r        <= aw_nxt;
      ah_r        <= ah_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    color_r     <= color_nxt;
    res_color_r <= res_color_nxt;
    res_area_r  <= res_area_nxt;
    out_color_r <= out_color_nxt;
    out_area_r  <= out_area_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.in_area     = out_area_r;

endmodule

`default_nettype wire

// ===== hdl/clr_checker.sv =====
`default_nettype none

`include "clipped_line_rasterizer_assert.svh"

module clr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input clr_pkg::color_t pixel_color,
  input logic            in_area
);

  // a waiting result holds
  `CLR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_color) && $stable(in_area))

  // one item at a time
  `CLR_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // clearing pass keeps the input closed right after reset
  `CLR_ASSERT_SAME(a_clear_first, clk, rst_n, $past(!rst_n), !in_ready)

  // a result outside the area carries no colour
  `CLR_ASSERT_SAME(a_zero_outside, clk, rst_n, out_valid && !in_area, pixel_color == '0)

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_color (out_ch.pixel_color),
  .in_area     (out_ch.in_area)
);

`default_nettype wire
